### hdl/isc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants for the insertion sorter
// Default sizes, count limit, controller states and the command/status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int MAX_KEYS_DEF = 32;
  localparam int KEY_BITS_DEF = 16;

  // port widths fixed by the item format
  localparam int KEY_W   = 16;
  localparam int COUNT_W = 11;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a key beat
    S_RD,     // read the entry just below the insert position
    S_CMP,    // compare key against that entry
    S_PUT,    // write the key at its final position
    S_ERD,    // read next entry for output
    S_ELD     // load output register
  } isc_state_t;

  typedef struct packed {
    logic accept;     // latch input beat
    logic set_ovf;    // store full, drop key
    logic rd_prev;    // read entry pos-1
    logic shift;      // move entry up one, count swap and compare
    logic count_cmp;  // failing compare that ends the walk
    logic put;        // write key at pos, bump fill
    logic emit_rd;    // read entry at output index
    logic emit_load;  // load output register, advance index
    logic clear;      // end of run, back to reset values
  } isc_cmd_t;

  typedef struct packed {
    logic full;       // fill count at capacity
    logic fill_zero;  // store empty
    logic pos_one;    // one step left before bottom
    logic less;       // key < entry read
    logic eor;        // latched end-of-run flag
    logic beat_eor;   // end-of-run flag on the offered beat
    logic emit_last;  // output index is the final entry
    logic out_free;   // output register can take a beat
  } isc_status_t;

endpackage : isc_pkg
`default_nettype wire

### hdl/isc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isc_ctrl: sequencer for the insertion sorter
// Walks each key down the store one entry per compare, then streams the
// sorted run out after the end-of-run key.
// ----------------------------------------------------------------------------
module isc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire isc_pkg::isc_status_t sts,
  output isc_pkg::isc_cmd_t        cmd
);
  import isc_pkg::*;

  isc_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.full) begin
            cmd.set_ovf = 1'b1;
            // a dropped final key still ends the run
            state_next  = sts.beat_eor ? S_ERD : S_IDLE;
          end else if (sts.fill_zero) begin
            state_next = S_PUT;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_prev = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        if (sts.less) begin
          cmd.shift  = 1'b1;
          state_next = sts.pos_one ? S_PUT : S_RD;
        end else begin
          cmd.count_cmp = 1'b1;
          state_next    = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = sts.eor ? S_ERD : S_IDLE;
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_ELD;
      end
      S_ELD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_ERD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // assertions
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_RD)
    else $error("compare without a preceding read");
  a_no_put_full: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> !sts.full)
    else $error("write into a full store");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> $past(state) == S_ERD || $past(state) == S_ELD)
    else $error("output load out of sequence");

endmodule : isc_ctrl
`default_nettype wire

### hdl/isc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isc_dp: datapath for the insertion sorter
// Key store memory, insert position, fill count, saturating counters and
// the output register.
// ----------------------------------------------------------------------------
module isc_dp #(
  parameter int MAX_KEYS = isc_pkg::MAX_KEYS_DEF,
  parameter int KEY_BITS = isc_pkg::KEY_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [isc_pkg::KEY_W-1:0]   key,
  input  wire logic                        end_of_run,
  input  wire isc_pkg::isc_cmd_t           cmd,
  output isc_pkg::isc_status_t             sts,
  output logic [isc_pkg::KEY_W-1:0]        sorted_key,
  output logic [isc_pkg::COUNT_W-1:0]      swap_count,
  output logic [isc_pkg::COUNT_W-1:0]      compare_count,
  output logic                             overflowed,
  output logic                             last_out,
  output logic                             out_valid,
  input  wire logic                        out_stall
);
  import isc_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((33'd1 << KB) - 33'd1);
  localparam logic [CW-1:0]    FULL_CNT = CW'(MAX_KEYS);

  logic [KEY_W-1:0]   mem [MAX_KEYS];
  logic [KEY_W-1:0]   rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [KEY_W-1:0]   wr_data;

  logic [KEY_W-1:0]   cur_key;
  logic               eor;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      idx;
  logic [CW-1:0]      fill;
  logic [COUNT_W-1:0] swap_total;
  logic [COUNT_W-1:0] compare_total;
  logic               ovf;

  // status back to the controller
  always_comb begin
    sts.full      = (fill == FULL_CNT);
    sts.fill_zero = (fill == '0);
    sts.pos_one   = (pos == AW'(1));
    sts.less      = (cur_key < rd_data);
    sts.eor       = eor;
    sts.beat_eor  = end_of_run;
    sts.emit_last = ((CW'(idx) + CW'(1)) == fill);
    sts.out_free  = !out_valid || !out_stall;
  end

  // memory ports
  assign rd_addr = cmd.emit_rd ? idx : pos - AW'(1);
  assign wr_en   = cmd.shift || cmd.put;
  assign wr_addr = pos;
  assign wr_data = cmd.shift ? rd_data : cur_key;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_prev || cmd.emit_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // input latch and insert position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_key <= key & KEY_MASK;
      pos     <= fill[AW-1:0];
    end else if (cmd.shift) begin
      pos <= pos - AW'(1);
    end
  end

  // run control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      eor           <= 1'b0;
      fill          <= '0;
      idx           <= '0;
      swap_total    <= '0;
      compare_total <= '0;
      ovf           <= 1'b0;
    end else begin
      if (cmd.accept) begin
        eor <= end_of_run;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.put) begin
        fill <= fill + CW'(1);
      end
      if (cmd.shift && swap_total != '1) begin
        swap_total <= swap_total + COUNT_W'(1);
      end
      if ((cmd.shift || cmd.count_cmp) && compare_total != '1) begin
        compare_total <= compare_total + COUNT_W'(1);
      end
      if (cmd.emit_load) begin
        idx <= idx + AW'(1);
      end
    end
  end

  // dropped final key: overflow drop on the end-of-run beat, checked below
  logic drop_emit;
  assign drop_emit = cmd.set_ovf && end_of_run;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      sorted_key    <= rd_data;
      swap_count    <= swap_total;
      compare_count <= compare_total;
      overflowed    <= ovf;
      last_out      <= sts.emit_last;
    end
  end

  // assertions
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill count beyond capacity");
  a_swap_le_cmp: assert property (@(posedge clk) disable iff (rst)
    swap_total <= compare_total)
    else $error("more swaps than compares");
  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> pos != '0)
    else $error("shift below the bottom of the store");
  a_drop_eor: assert property (@(posedge clk) disable iff (rst)
    drop_emit |=> !eor || ovf)
    else $error("dropped final key lost its overflow flag");

endmodule : isc_dp
`default_nettype wire

### hdl/insertion_sort_with_counts_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sort_with_counts_top: stable insertion sorter with counts
// Per key: accept (S_IDLE), then per compare a memory read (S_RD) and a
//   compare (S_CMP), then the write (S_PUT); a dropped key is never written.
// After the final key, each sorted result is read out (S_ERD) and loaded
//   into the output register (S_ELD), which waits out any output stall.
// Input is stalled while a key walks down the store or a run drains.
// Reset (rst, synchronous) clears fill count, counters and flags; the key
//   store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module insertion_sort_with_counts_top #(
  parameter int MAX_KEYS = isc_pkg::MAX_KEYS_DEF,
  parameter int KEY_BITS = isc_pkg::KEY_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [isc_pkg::KEY_W-1:0]   key,
  input  wire logic                        end_of_run,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [isc_pkg::KEY_W-1:0]        sorted_key,
  output logic [isc_pkg::COUNT_W-1:0]      swap_count,
  output logic [isc_pkg::COUNT_W-1:0]      compare_count,
  output logic                             overflowed,
  output logic                             last_out
);
  import isc_pkg::*;

  isc_cmd_t    cmd;
  isc_status_t sts;

  isc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  isc_dp #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .key           (key),
    .end_of_run    (end_of_run),
    .cmd           (cmd),
    .sts           (sts),
    .sorted_key    (sorted_key),
    .swap_count    (swap_count),
    .compare_count (compare_count),
    .overflowed    (overflowed),
    .last_out      (last_out),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule : insertion_sort_with_counts_top
`default_nettype wire
